// ===== hw/rtl/tse_pkg.sv =====
`timescale 1ns / 1ps

package tse_pkg;

    // Field widths
    localparam int ANGLE_W = 32;
    localparam int COUNT_W = 4;
    localparam int OUT_W   = 40;
    localparam int IN_TDATA_W = 40;

    // Defaults for the top-level parameters
    localparam int MAX_TERMS_DEF     = 10;
    localparam int FRACTION_BITS_DEF = 28;

    // Datapath widths: every magnitude is clamped to 2^58, so 59 bits hold it
    localparam int OP_W    = 59;
    localparam int HALF_W  = 32;
    localparam int ACC_W   = 2 * OP_W;
    localparam int SUM_W   = 64;
    localparam int KW      = 5;
    localparam int PP_W    = 3;
    localparam int TABLE_N = 16;

    localparam logic [OP_W-1:0] MAG_LIMIT = OP_W'(1) << (OP_W - 1);
    localparam logic signed [SUM_W-1:0] SUM_MAX = 64'sd549755813887;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -64'sd549755813888;
    localparam logic [OUT_W-1:0] OUT_MAX = 40'h7f_ffff_ffff;

    // Partial product schedule: four products, then one drain step
    localparam logic [PP_W-1:0] PP_LAST = 3'd4;

    // round(2^32 / ((2k)(2k+1))), index k; entry zero is never read
    localparam logic [31:0] RECIP_TABLE [TABLE_N] = '{
        32'd0,        32'd715827883, 32'd214748365, 32'd102261126,
        32'd59652324, 32'd39045157,  32'd27531842,  32'd20452225,
        32'd15790321, 32'd12558384,  32'd10226113,  32'd8488078,
        32'd7158279,  32'd6118187,   32'd5289369,   32'd4618244
    };

    typedef enum logic [1:0] {
        MUL_SQ,
        MUL_GAIN,
        MUL_TERM
    } mul_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_MUL,
        ST_SQ_RND,
        ST_GAIN_MUL,
        ST_GAIN_RND,
        ST_TERM_MUL,
        ST_TERM_RND,
        ST_FINISH
    } ctl_state_t;

    typedef struct packed {
        logic            load;
        logic            pp_en;
        logic [PP_W-1:0] pp_idx;
        logic            round_en;
        mul_sel_t        mul_sel;
        logic            out_load;
    } cmd_t;

    typedef struct packed {
        logic in_bad;
        logic k_le_n;
        logic k_lt_n;
        logic out_free;
    } status_t;

endpackage

// ===== hw/rtl/taylor_sine_evaluator_unit.sv =====
`timescale 1ns / 1ps
// Channel   Dir   Bits   Contents (lowest bit up)
// s_*       in    40     tdata: angle[31:0], term_count[35:32], zero pad
// m_*       out   40+1   tdata: sine_value[39:0]; tuser: bad_count
//
// One word at a time. Each 59x59 product runs on one shared 32x32 multiplier:
// four partial products, then a drain step and a round step.
// A word squares the angle, then runs a gain and a term product per term;
// a count above MAX_TERMS goes straight to the finish state and returns the error value.
// Reset clears the controller and the output valid; no clearing pass.
// The output register lets the next word be taken while a result waits.

module taylor_sine_evaluator_unit #(
    parameter int MAX_TERMS     = tse_pkg::MAX_TERMS_DEF,
    parameter int FRACTION_BITS = tse_pkg::FRACTION_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tse_pkg::IN_TDATA_W-1:0] s_tdata,  // angle, term_count, pad
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tse_pkg::OUT_W-1:0]      m_tdata,  // sine_value
    output logic                           m_tuser   // bad_count
);
    import tse_pkg::*;

    cmd_t    cmd;
    status_t status;

    tse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tse_datapath #(
        .MAX_TERMS     (MAX_TERMS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

// ===== hw/rtl/tse_ctrl.sv =====
`timescale 1ns / 1ps

module tse_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  tse_pkg::status_t status,
    output tse_pkg::cmd_t    cmd
);
    import tse_pkg::*;

    ctl_state_t      state_reg, state_next;
    logic [PP_W-1:0] pp_reg, pp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pp_reg    <= pp_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pp_next    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = status.in_bad ? ST_FINISH : ST_SQ_MUL;
            end
            ST_SQ_MUL, ST_GAIN_MUL, ST_TERM_MUL:
            begin
                if (pp_reg == PP_LAST)
                begin
                    unique case (state_reg)
                        ST_SQ_MUL:   state_next = ST_SQ_RND;
                        ST_GAIN_MUL: state_next = ST_GAIN_RND;
                        default:     state_next = ST_TERM_RND;
                    endcase
                end
                else
                    pp_next = pp_reg + PP_W'(1);
            end
            ST_SQ_RND:
                state_next = status.k_le_n ? ST_GAIN_MUL : ST_FINISH;
            ST_GAIN_RND:
                state_next = ST_TERM_MUL;
            ST_TERM_RND:
                state_next = status.k_lt_n ? ST_GAIN_MUL : ST_FINISH;
            ST_FINISH:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.pp_idx  = pp_reg;
        cmd.mul_sel = MUL_SQ;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SQ_MUL:
                cmd.pp_en = 1'b1;
            ST_SQ_RND:
                cmd.round_en = 1'b1;
            ST_GAIN_MUL:
            begin
                cmd.pp_en   = 1'b1;
                cmd.mul_sel = MUL_GAIN;
            end
            ST_GAIN_RND:
            begin
                cmd.round_en = 1'b1;
                cmd.mul_sel  = MUL_GAIN;
            end
            ST_TERM_MUL:
            begin
                cmd.pp_en   = 1'b1;
                cmd.mul_sel = MUL_TERM;
            end
            ST_TERM_RND:
            begin
                cmd.round_en = 1'b1;
                cmd.mul_sel  = MUL_TERM;
            end
            ST_FINISH:
                cmd.out_load = status.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule

// ===== hw/rtl/tse_datapath.sv =====
`timescale 1ns / 1ps

module tse_datapath #(
    parameter int MAX_TERMS     = tse_pkg::MAX_TERMS_DEF,
    parameter int FRACTION_BITS = tse_pkg::FRACTION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tse_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tse_pkg::OUT_W-1:0]     m_tdata,
    output logic                          m_tuser,
    input  tse_pkg::cmd_t                 cmd,
    output tse_pkg::status_t              status
);
    import tse_pkg::*;

    localparam logic [OUT_W-1:0] ERR_VALUE =
        (FRACTION_BITS <= OUT_W - 3) ? OUT_W'(64'd2 << FRACTION_BITS) : OUT_MAX;
    localparam logic [ACC_W:0] HALF_F  = (ACC_W + 1)'(1) << (FRACTION_BITS - 1);
    localparam logic [ACC_W:0] HALF_32 = (ACC_W + 1)'(1) << (HALF_W - 1);

    logic [ANGLE_W-1:0] in_angle;
    logic [COUNT_W-1:0] in_count;
    logic [ANGLE_W-1:0] in_mag;

    logic [ANGLE_W-1:0] n_mag_reg;
    logic [COUNT_W-1:0] n_reg;
    logic [KW-1:0]      k_reg;
    logic               bad_reg;
    logic [OP_W-1:0]    sq_reg;
    logic [OP_W-1:0]    g_reg;
    logic [OP_W-1:0]    term_reg;
    logic               tneg_reg;
    logic [SUM_W-1:0]   sum_reg;

    logic [OP_W-1:0]    op_a, op_b;
    logic [HALF_W-1:0]  half_a, half_b;
    logic [2*HALF_W-1:0] prod_reg;
    logic [1:0]         pend_sh_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   pp_aligned;

    logic [ACC_W:0]     rsum;
    logic [ACC_W:0]     rshift;
    logic [OP_W-1:0]    rnd_val;
    logic [SUM_W-1:0]   term_ext;

    logic [SUM_W-1:0]   init_sum;
    logic [OUT_W-1:0]   sat_val;

    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;
    logic               out_bad_reg;

    assign in_angle = s_tdata[ANGLE_W-1:0];
    assign in_count = s_tdata[ANGLE_W +: COUNT_W];
    // Two's complement negation; the most negative angle becomes 2^31
    assign in_mag   = in_angle[ANGLE_W-1] ? (~in_angle + ANGLE_W'(1)) : in_angle;
    assign init_sum = in_angle[ANGLE_W-1] ? (SUM_W'(0) - SUM_W'(in_mag)) : SUM_W'(in_mag);

    assign status.in_bad   = (32'(in_count) > 32'(MAX_TERMS));
    assign status.k_le_n   = (k_reg <= KW'(n_reg));
    assign status.k_lt_n   = (k_reg < KW'(n_reg));
    assign status.out_free = !out_valid_reg || m_tready;

    // Operand select for the shared multiplier
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_SQ:
            begin
                op_a = OP_W'(n_mag_reg);
                op_b = OP_W'(n_mag_reg);
            end
            MUL_GAIN:
            begin
                op_a = sq_reg;
                op_b = OP_W'(RECIP_TABLE[k_reg[3:0]]);
            end
            MUL_TERM:
            begin
                op_a = term_reg;
                op_b = g_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // pp_idx bit 1 picks the upper half of a, bit 0 the upper half of b
    assign half_a = cmd.pp_idx[1] ? HALF_W'(op_a[OP_W-1:HALF_W]) : op_a[HALF_W-1:0];
    assign half_b = cmd.pp_idx[0] ? HALF_W'(op_b[OP_W-1:HALF_W]) : op_b[HALF_W-1:0];

    always_comb
    begin
        unique case (pend_sh_reg)
            2'd0:    pp_aligned = ACC_W'(prod_reg);
            2'd1:    pp_aligned = ACC_W'(prod_reg) << HALF_W;
            2'd2:    pp_aligned = ACC_W'(prod_reg) << (2 * HALF_W);
            default: pp_aligned = '0;
        endcase
    end

    // Round half up, then clamp the magnitude
    always_comb
    begin
        if (cmd.mul_sel == MUL_GAIN)
        begin
            rsum   = {1'b0, acc_reg} + HALF_32;
            rshift = rsum >> HALF_W;
        end
        else
        begin
            rsum   = {1'b0, acc_reg} + HALF_F;
            rshift = rsum >> FRACTION_BITS;
        end
        rnd_val = (rshift > (ACC_W + 1)'(MAG_LIMIT)) ? MAG_LIMIT : rshift[OP_W-1:0];
    end

    assign term_ext = SUM_W'(rnd_val);

    always_comb
    begin
        priority if ($signed(sum_reg) > SUM_MAX)
            sat_val = OUT_MAX;
        else if ($signed(sum_reg) < SUM_MIN)
            sat_val = ~OUT_MAX;
        else
            sat_val = sum_reg[OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_mag_reg <= in_mag;
            n_reg     <= in_count;
            bad_reg   <= status.in_bad;
            k_reg     <= KW'(1);
            term_reg  <= OP_W'(in_mag);
            tneg_reg  <= in_angle[ANGLE_W-1];
            sum_reg   <= init_sum;
        end

        if (cmd.pp_en)
        begin
            if (cmd.pp_idx != PP_LAST)
            begin
                prod_reg    <= half_a * half_b;
                pend_sh_reg <= 2'(cmd.pp_idx[1]) + 2'(cmd.pp_idx[0]);
            end
            if (cmd.pp_idx == '0)
                acc_reg <= '0;
            else
                acc_reg <= acc_reg + pp_aligned;
        end

        if (cmd.round_en)
        begin
            unique case (cmd.mul_sel)
                MUL_SQ:
                    sq_reg <= rnd_val;
                MUL_GAIN:
                    g_reg <= rnd_val;
                MUL_TERM:
                begin
                    term_reg <= rnd_val;
                    tneg_reg <= !tneg_reg;
                    // New sign is the flipped one
                    if (!tneg_reg)
                        sum_reg <= sum_reg - term_ext;
                    else
                        sum_reg <= sum_reg + term_ext;
                    k_reg <= k_reg + KW'(1);
                end
                default:
                    sq_reg <= sq_reg;
            endcase
        end

        if (cmd.out_load)
        begin
            out_data_reg <= bad_reg ? ERR_VALUE : sat_val;
            out_bad_reg  <= bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_bad_reg;

endmodule
